// ===== rtl/cglvg_pkg.sv =====
// cglvg_pkg: shared constants, register indexes and control structs of the
// capture gain limiter and voice gate. No dependencies; every other rtl file
// but cglvg_ram uses it through scoped names.
package cglvg_pkg;

    // curve memory defaults and word widths
    localparam int CURVE_DEPTH = 32768;
    localparam int CURVE_W     = 12;

    // sample path widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 15;
    localparam int MAG_W    = 18;
    localparam int OPEN_W   = 14;
    localparam int CLOSE_W  = 13;
    localparam int HOLD_W   = 8;
    localparam int COUNT_W  = 11;
    localparam int ENERGY_W = 41;

    // limiter and gate constants
    localparam int KNEE       = 30000;
    localparam int SPAN       = 2600;
    localparam int SPEAK_PEAK = 500;
    localparam int COUNT_MAX  = 2047;
    localparam int POS_MAX    = 32767;
    localparam int NEG_MAX    = 32768;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TX_ENABLE   = 3'd5;

    localparam logic [GAIN_W-1:0]  RST_GAIN        = 15'd5530;
    localparam logic               RST_GATE_ENABLE = 1'b0;
    localparam logic [OPEN_W-1:0]  RST_OPEN_LEVEL  = 14'd655;
    localparam logic [CLOSE_W-1:0] RST_CLOSE_LEVEL = 13'd426;
    localparam logic [HOLD_W-1:0]  RST_HOLD_FRAMES = 8'd14;
    localparam logic               RST_TX_ENABLE   = 1'b1;

    // exp(-1/2600) in unsigned q52, alternating series with truncated terms
    localparam logic [63:0] Q52_UNITY    = 64'd1 << 52;
    localparam logic [63:0] RATIO_TERM_1 = Q52_UNITY / 64'(SPAN * 1);
    localparam logic [63:0] RATIO_TERM_2 = RATIO_TERM_1 / 64'(SPAN * 2);
    localparam logic [63:0] RATIO_TERM_3 = RATIO_TERM_2 / 64'(SPAN * 3);
    localparam logic [63:0] RATIO_TERM_4 = RATIO_TERM_3 / 64'(SPAN * 4);
    localparam logic [63:0] RATIO_TERM_5 = RATIO_TERM_4 / 64'(SPAN * 5);
    localparam logic [63:0] RATIO_TERM_6 = RATIO_TERM_5 / 64'(SPAN * 6);
    localparam logic [63:0] RATIO_TERM_7 = RATIO_TERM_6 / 64'(SPAN * 7);
    localparam logic [63:0] RATIO_TERM_8 = RATIO_TERM_7 / 64'(SPAN * 8);

    localparam logic [63:0] CURVE_RATIO = Q52_UNITY - RATIO_TERM_1 + RATIO_TERM_2
                                        - RATIO_TERM_3 + RATIO_TERM_4 - RATIO_TERM_5
                                        + RATIO_TERM_6 - RATIO_TERM_7 + RATIO_TERM_8;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic look;
        logic mag;
        logic square;
        logic acc;
        logic emit_sample;
        logic thr;
        logic decide;
    } cglvg_cmd_t;

    // datapath and curve filler to controller
    typedef struct packed {
        logic fill_done;
        logic frame_last;
        logic out_free;
    } cglvg_stat_t;

endpackage

// ===== rtl/cglvg_if.sv =====
// cglvg_if: valid/ready channel interfaces for capture words, result words and
// configuration writes. Depends on cglvg_pkg for field widths.

interface cglvg_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cglvg_pkg::SAMPLE_W-1:0] in_sample;
    logic                                  frame_last;

    modport source (output valid, output in_sample, output frame_last, input ready);
    modport sink   (input valid, input in_sample, input frame_last, output ready);
endinterface

interface cglvg_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cglvg_pkg::SAMPLE_W-1:0] out_sample;
    logic                                  frame_done;
    logic        [cglvg_pkg::SAMPLE_W-1:0] frame_peak;
    logic                                  gate_open;
    logic                                  transmit;
    logic                                  speaking;

    modport source (output valid, output out_sample, output frame_done, output frame_peak,
                    output gate_open, output transmit, output speaking, input ready);
    modport sink   (input valid, input out_sample, input frame_done, input frame_peak,
                    input gate_open, input transmit, input speaking, output ready);
endinterface

interface cglvg_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [cglvg_pkg::CFG_IDX_W-1:0]     index;
    logic [cglvg_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/capture_gain_limiter_voice_gate_unit.sv =====
// capture_gain_limiter_voice_gate_unit: capture gain, soft knee limiter and
// frame rms voice gate. A new word is not taken before the last one is done,
// set by the controller's step chain and the curve memory's registered read;
// a full result register stalls it. Reset clears the gate, the frame
// accumulators and restores register defaults, then the curve is built into
// memory before a word is taken.
module capture_gain_limiter_voice_gate_unit #(
    parameter int CURVE_DEPTH = cglvg_pkg::CURVE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    cglvg_in_if.sink    capture,
    cglvg_out_if.source result,
    cglvg_cfg_if.sink   cfg
);

    localparam int AW = $clog2(CURVE_DEPTH);

    cglvg_pkg::cglvg_cmd_t  cmd;
    cglvg_pkg::cglvg_stat_t stat;

    // curve memory ports
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [cglvg_pkg::CURVE_W-1:0] wr_data;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [cglvg_pkg::CURVE_W-1:0] rd_data;

    logic fill_done;
    logic frame_last_q;
    logic out_free;

    // registers are always writable; the host writes only while idle, which the unit does not enforce
    assign cfg.ready = 1'b1;

    assign stat.fill_done  = fill_done;
    assign stat.frame_last = frame_last_q;
    assign stat.out_free   = out_free;

    // builds the limiter curve after reset
    cglvg_curve_fill #(
        .CURVE_DEPTH (CURVE_DEPTH)
    ) u_fill (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .done    (fill_done)
    );

    // limiter curve, written by the filler, read by the sample path
    cglvg_ram #(
        .WIDTH (cglvg_pkg::CURVE_W),
        .DEPTH (CURVE_DEPTH)
    ) u_curve (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // one word at a time: look, limit, square, accumulate, frame decision
    cglvg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (capture.valid),
        .in_ready (capture.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cglvg_datapath #(
        .CURVE_DEPTH (CURVE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .frame_last_q (frame_last_q),
        .out_free     (out_free),
        .in_sample    (capture.in_sample),
        .frame_last   (capture.frame_last),
        .cfg_write    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_sample   (result.out_sample),
        .frame_done   (result.frame_done),
        .frame_peak   (result.frame_peak),
        .gate_open    (result.gate_open),
        .transmit     (result.transmit),
        .speaking     (result.speaking)
    );

endmodule

// ===== rtl/cglvg_ram.sv =====
// cglvg_ram: generic simple dual port ram, one write and one registered read.
// No dependencies.
module cglvg_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32768,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cglvg_curve_fill.sv =====
// cglvg_curve_fill: after reset builds the soft limiter curve into the ram,
// one q52 decay step per entry on a shared 27x26 multiplier. Depends on cglvg_pkg.
module cglvg_curve_fill #(
    parameter int CURVE_DEPTH = cglvg_pkg::CURVE_DEPTH,
    localparam int AW         = $clog2(CURVE_DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [cglvg_pkg::CURVE_W-1:0] wr_data,
    output logic                          done
);

    localparam logic [2:0] PH_ZERO  = 3'd0;
    localparam logic [2:0] PH_LL    = 3'd1;
    localparam logic [2:0] PH_HL    = 3'd2;
    localparam logic [2:0] PH_LH    = 3'd3;
    localparam logic [2:0] PH_HH    = 3'd4;
    localparam logic [2:0] PH_SUM   = 3'd5;
    localparam logic [2:0] PH_WRITE = 3'd6;
    localparam logic [2:0] PH_DONE  = 3'd7;

    localparam logic [25:0] R_HI = cglvg_pkg::CURVE_RATIO[51:26];
    localparam logic [25:0] R_LO = cglvg_pkg::CURVE_RATIO[25:0];
    localparam logic [52:0] Q52_ONE = 53'd1 << 52;

    logic [2:0]    phase_reg, phase_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [52:0]   p_reg, p_next;
    logic [52:0]   prod_reg, prod_next;
    logic [54:0]   mid_reg, mid_next;
    logic          done_reg, done_next;

    logic [26:0] a_op;
    logic [25:0] b_op;
    logic [52:0] mul_out;
    logic [52:0] q;
    logic [63:0] scaled;

    // operand select for the four partial products
    always_comb
    begin
        case (phase_reg)
            PH_LL:   begin a_op = {1'b0, p_reg[25:0]}; b_op = R_LO; end
            PH_HL:   begin a_op = p_reg[52:26];        b_op = R_LO; end
            PH_LH:   begin a_op = {1'b0, p_reg[25:0]}; b_op = R_HI; end
            default: begin a_op = p_reg[52:26];        b_op = R_HI; end
        endcase
    end

    assign mul_out = a_op * b_op;

    // entry = round(2600 * (1 - p)), 2600 = 2^11 + 2^9 + 2^5 + 2^3
    assign q      = Q52_ONE - p_reg;
    assign scaled = (64'(q) << 11) + (64'(q) << 9) + (64'(q) << 5) + (64'(q) << 3)
                  + (64'd1 << 51);

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        p_next     = p_reg;
        prod_next  = prod_reg;
        mid_next   = mid_reg;
        done_next  = done_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = scaled[63:52];
        case (phase_reg)
            PH_ZERO:
            begin
                wr_en      = 1'b1;
                wr_data    = '0;
                idx_next   = AW'(1);
                p_next     = Q52_ONE;
                phase_next = PH_LL;
            end
            PH_LL:
            begin
                prod_next  = mul_out;
                phase_next = PH_HL;
            end
            PH_HL:
            begin
                mid_next   = 55'(prod_reg[52:26]);
                prod_next  = mul_out;
                phase_next = PH_LH;
            end
            PH_LH:
            begin
                mid_next   = mid_reg + 55'(prod_reg);
                prod_next  = mul_out;
                phase_next = PH_HH;
            end
            PH_HH:
            begin
                mid_next   = mid_reg + 55'(prod_reg);
                prod_next  = mul_out;
                phase_next = PH_SUM;
            end
            PH_SUM:
            begin
                p_next     = prod_reg + 53'(mid_reg[54:26]);
                phase_next = PH_WRITE;
            end
            PH_WRITE:
            begin
                wr_en = 1'b1;
                if (idx_reg == AW'(CURVE_DEPTH - 1))
                begin
                    done_next  = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    phase_next = PH_LL;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ZERO;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        prod_reg <= prod_next;
        mid_reg  <= mid_next;
    end

    assign done = done_reg;

endmodule

// ===== rtl/cglvg_ctrl.sv =====
// cglvg_ctrl: sequencer for one capture word at a time, issues datapath
// commands. Depends on cglvg_pkg.
module cglvg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cglvg_pkg::cglvg_stat_t stat,
    output cglvg_pkg::cglvg_cmd_t  cmd
);

    localparam logic [2:0] ST_FILL = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_LOOK = 3'd2;
    localparam logic [2:0] ST_MAG  = 3'd3;
    localparam logic [2:0] ST_SQ   = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;
    localparam logic [2:0] ST_THR  = 3'd6;
    localparam logic [2:0] ST_DEC  = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_FILL:
                if (stat.fill_done)
                    state_next = ST_IDLE;
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.square = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
                if (stat.frame_last)
                begin
                    cmd.acc    = 1'b1;
                    state_next = ST_THR;
                end
                else if (stat.out_free)
                begin
                    cmd.acc         = 1'b1;
                    cmd.emit_sample = 1'b1;
                    state_next      = ST_IDLE;
                end
            ST_THR:
            begin
                cmd.thr    = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC:
                if (stat.out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_FILL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_FILL;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/cglvg_datapath.sv =====
// cglvg_datapath: configuration registers, gain and limiter path, frame
// accumulators, gate decision and output register. Depends on cglvg_pkg.
module cglvg_datapath #(
    parameter int CURVE_DEPTH = cglvg_pkg::CURVE_DEPTH,
    localparam int AW         = $clog2(CURVE_DEPTH)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cglvg_pkg::cglvg_cmd_t                 cmd,
    output logic                                  frame_last_q,
    output logic                                  out_free,
    input  logic signed [cglvg_pkg::SAMPLE_W-1:0] in_sample,
    input  logic                                  frame_last,
    input  logic                                  cfg_write,
    input  logic [cglvg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cglvg_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                  rd_en,
    output logic [AW-1:0]                         rd_addr,
    input  logic [cglvg_pkg::CURVE_W-1:0]         rd_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [cglvg_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                  frame_done,
    output logic [cglvg_pkg::SAMPLE_W-1:0]        frame_peak,
    output logic                                  gate_open,
    output logic                                  transmit,
    output logic                                  speaking
);

    localparam int SW  = cglvg_pkg::SAMPLE_W;
    localparam int MW  = cglvg_pkg::MAG_W;
    localparam int CW  = cglvg_pkg::COUNT_W;
    localparam int EW  = cglvg_pkg::ENERGY_W;
    localparam int HW  = cglvg_pkg::HOLD_W;
    localparam int OW  = cglvg_pkg::OPEN_W;
    localparam int LW  = cglvg_pkg::CLOSE_W;

    // configuration
    logic [cglvg_pkg::GAIN_W-1:0] gain_reg;
    logic                         gate_en_reg;
    logic [OW-1:0]                open_reg;
    logic [LW-1:0]                close_reg;
    logic [HW-1:0]                hold_frames_reg;
    logic                         tx_en_reg;

    // per-word payload
    logic            neg_reg;
    logic            last_reg;
    logic [MW-1:0]   m_reg;
    logic [SW-1:0]   res_reg;
    logic [31:0]     sq_reg;
    logic [2*OW-1:0] ol2_reg;
    logic [2*LW-1:0] cl2_reg;
    logic [2*OW+CW-1:0] thr_open_reg;
    logic [2*LW+CW-1:0] thr_close_reg;

    // frame state
    logic [SW-1:0] peak_reg;
    logic [EW-1:0] energy_reg;
    logic [CW-1:0] count_reg;
    logic          gate_reg, gate_next;
    logic [HW-1:0] hold_reg, hold_next;

    // output register
    logic          out_valid_reg;
    logic [SW-1:0] out_sample_reg;
    logic          out_done_reg;
    logic [SW-1:0] out_peak_reg;
    logic          out_gate_reg;
    logic          out_tx_reg;
    logic          out_speak_reg;

    logic [SW:0]   amag;
    logic [31:0]   gained;
    logic [MW-1:0] excess;
    logic          over_knee;
    logic [SW-1:0] lim;
    logic [SW-1:0] res_val;
    logic [SW-1:0] signed_res;
    logic [HW-1:0] hold_dec;
    logic          above_open;
    logic          below_close;
    logic          active;
    logic          tx;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= cglvg_pkg::RST_GAIN;
            gate_en_reg     <= cglvg_pkg::RST_GATE_ENABLE;
            open_reg        <= cglvg_pkg::RST_OPEN_LEVEL;
            close_reg       <= cglvg_pkg::RST_CLOSE_LEVEL;
            hold_frames_reg <= cglvg_pkg::RST_HOLD_FRAMES;
            tx_en_reg       <= cglvg_pkg::RST_TX_ENABLE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cglvg_pkg::REG_GAIN:        gain_reg        <= cfg_data;
                cglvg_pkg::REG_GATE_ENABLE: gate_en_reg     <= cfg_data[0];
                cglvg_pkg::REG_OPEN_LEVEL:  open_reg        <= cfg_data[OW-1:0];
                cglvg_pkg::REG_CLOSE_LEVEL: close_reg       <= cfg_data[LW-1:0];
                cglvg_pkg::REG_HOLD_FRAMES: hold_frames_reg <= cfg_data[HW-1:0];
                cglvg_pkg::REG_TX_ENABLE:   tx_en_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // gain and round half away from zero on the magnitude
    assign amag   = in_sample[SW-1] ? (SW+1)'(-$signed({in_sample[SW-1], in_sample}))
                                    : {1'b0, in_sample};
    assign gained = 32'(amag) * 32'(gain_reg) + 32'd2048;

    // curve lookup address, saturated at the last entry
    assign over_knee = m_reg > MW'(cglvg_pkg::KNEE);
    assign excess    = m_reg - MW'(cglvg_pkg::KNEE);
    assign rd_en     = cmd.look;
    assign rd_addr   = ({1'b0, excess} >= (MW+1)'(CURVE_DEPTH)) ? AW'(CURVE_DEPTH - 1)
                                                               : excess[AW-1:0];

    // limiter and clamp
    always_comb
    begin
        lim = over_knee ? SW'(cglvg_pkg::KNEE) + SW'(rd_data) : m_reg[SW-1:0];
        if (!neg_reg && lim > SW'(cglvg_pkg::POS_MAX))
            res_val = SW'(cglvg_pkg::POS_MAX);
        else if (lim > SW'(cglvg_pkg::NEG_MAX))
            res_val = SW'(cglvg_pkg::NEG_MAX);
        else
            res_val = lim;
    end

    assign signed_res = neg_reg ? SW'(-res_reg) : res_reg;

    // gate decision at frame end
    assign hold_dec    = (hold_reg != '0) ? hold_reg - HW'(1) : hold_reg;
    assign above_open  = energy_reg >= EW'(thr_open_reg);
    assign below_close = energy_reg < EW'(thr_close_reg);

    always_comb
    begin
        gate_next = gate_reg;
        hold_next = hold_dec;
        if (gate_en_reg)
        begin
            if (above_open)
            begin
                gate_next = 1'b1;
                hold_next = hold_frames_reg;
            end
            else if (gate_reg && below_close && hold_dec == '0)
                gate_next = 1'b0;
            active = gate_next;
        end
        else
        begin
            gate_next = 1'b0;
            active    = 1'b1;
        end
    end

    assign tx = tx_en_reg && active;

    // word payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            neg_reg  <= in_sample[SW-1];
            last_reg <= frame_last;
            m_reg    <= gained[MW+11:12];
        end
        if (cmd.mag)
            res_reg <= res_val;
        if (cmd.square)
        begin
            sq_reg  <= res_reg * res_reg;
            ol2_reg <= open_reg * open_reg;
            cl2_reg <= close_reg * close_reg;
        end
        if (cmd.thr)
        begin
            thr_open_reg  <= ol2_reg * count_reg;
            thr_close_reg <= cl2_reg * count_reg;
        end
    end

    // frame accumulators and gate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg   <= '0;
            energy_reg <= '0;
            count_reg  <= '0;
            gate_reg   <= 1'b0;
            hold_reg   <= '0;
        end
        else if (cmd.acc)
        begin
            if (res_reg > peak_reg)
                peak_reg <= res_reg;
            if (count_reg < CW'(cglvg_pkg::COUNT_MAX))
            begin
                energy_reg <= energy_reg + EW'(sq_reg);
                count_reg  <= count_reg + CW'(1);
            end
        end
        else if (cmd.decide)
        begin
            gate_reg   <= gate_next;
            hold_reg   <= hold_next;
            peak_reg   <= '0;
            energy_reg <= '0;
            count_reg  <= '0;
        end
    end

    // output word register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_sample || cmd.decide)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_sample)
        begin
            out_sample_reg <= signed_res;
            out_done_reg   <= 1'b0;
            out_peak_reg   <= '0;
            out_gate_reg   <= 1'b0;
            out_tx_reg     <= 1'b0;
            out_speak_reg  <= 1'b0;
        end
        else if (cmd.decide)
        begin
            out_sample_reg <= signed_res;
            out_done_reg   <= 1'b1;
            out_peak_reg   <= peak_reg;
            out_gate_reg   <= gate_next;
            out_tx_reg     <= tx;
            out_speak_reg  <= tx && (peak_reg > SW'(cglvg_pkg::SPEAK_PEAK));
        end
    end

    assign frame_last_q = last_reg;
    assign out_valid    = out_valid_reg;
    assign out_sample   = $signed(out_sample_reg);
    assign frame_done   = out_done_reg;
    assign frame_peak   = out_peak_reg;
    assign gate_open    = out_gate_reg;
    assign transmit     = out_tx_reg;
    assign speaking     = out_speak_reg;

endmodule

// ===== tb/sv/capture_gain_limiter_voice_gate_unit_tb.sv =====
`timescale 1ns / 100ps
// tb: regression bench for capture_gain_limiter_voice_gate_unit, checking every result word
// against an in-bench model of the gain, soft knee limiter and frame voice gate.
// Depends on cglvg_pkg, the cglvg_if channel interfaces and the unit itself.
module tb;
    import cglvg_pkg::*;

    localparam int KNEE_DEPTH      = CURVE_DEPTH;
    // longest quiet stretch of a correct run is the curve fill after reset
    localparam int QUIET_LIMIT     = 600000;
    localparam int TAIL_CYCLES     = 12;
    localparam int RANDOM_WORDS    = 1080;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic [63:0] Q52_UNIT = 64'd1 << 52;

    // amplitude classes for generated capture words
    typedef enum int {LEVEL_QUIET, LEVEL_MID, LEVEL_LOUD, LEVEL_WILD, LEVEL_MIXED} level_t;

    // one result word as the unit should present it
    typedef struct {
        logic [15:0] sample;
        logic        done;
        logic [15:0] peak;
        logic        gate;
        logic        tx;
        logic        speak;
    } voice_word_t;

    logic clk;
    logic rst_n;

    cglvg_in_if  capture_ch ();
    cglvg_out_if result_ch ();
    cglvg_cfg_if cfg_ch ();

    capture_gain_limiter_voice_gate_unit #(
        .CURVE_DEPTH(KNEE_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .capture(capture_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // soft knee curve: 2600 * (1 - exp(-e / 2600)), rounded, built in q52
    logic [15:0] knee_curve [KNEE_DEPTH];

    // register copies as the unit should hold them
    logic [GAIN_W-1:0]  gain_setting;
    logic               gate_on;
    logic [OPEN_W-1:0]  open_thresh;
    logic [CLOSE_W-1:0] close_thresh;
    logic [HOLD_W-1:0]  hold_setting;
    logic               tx_on;

    // frame accumulators and gate state
    logic [15:0]        peak_so_far;
    logic [63:0]        energy_so_far;
    logic [COUNT_W-1:0] words_in_frame;
    logic               gate_is_open;
    logic [HOLD_W-1:0]  hold_left;

    // result words still owed by the unit, oldest first
    voice_word_t expected_words[$];

    int fails          = 0;
    int quiet_cycles   = 0;
    int hold_off_asked = 0;
    int hold_off_given = 0;
    int sink_stall     = 0;
    bit source_idles   = 1'b1;
    bit sink_idles     = 1'b1;

    // 20 ns clock, starts high
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [15:0] with_sign(int unsigned mag);
        return ($urandom_range(0, 1) != 0) ? 16'(32'h10000 - mag) : 16'(mag);
    endfunction

    function automatic logic [15:0] pick_word(level_t level);
        level_t lvl;
        lvl = level;
        if (lvl == LEVEL_MIXED)
            lvl = level_t'($urandom_range(0, 3));
        case (lvl)
            LEVEL_QUIET: return with_sign($urandom_range(0, 60));
            LEVEL_MID:   return with_sign($urandom_range(61, 3000));
            LEVEL_LOUD:  return with_sign($urandom_range(3001, 32768));
            default:     return 16'($urandom);
        endcase
    endfunction

    // exp(-1/2600) by a truncated alternating series, then repeated q52 products
    task automatic build_knee_curve();
        logic [63:0]  term;
        logic [63:0]  ratio;
        logic [63:0]  pw;
        logic [127:0] prod;
        term  = Q52_UNIT;
        ratio = Q52_UNIT;
        pw    = Q52_UNIT;
        for (int k = 1; k <= 8; k++)
        begin
            term = term / (64'(SPAN) * 64'(k));
            if ((k % 2) == 1)
                ratio = ratio - term;
            else
                ratio = ratio + term;
        end
        knee_curve[0] = 16'd0;
        for (int i = 1; i < KNEE_DEPTH; i++)
        begin
            prod = {64'd0, pw} * {64'd0, ratio};
            pw   = prod[115:52];
            knee_curve[i] = 16'((64'(SPAN) * (Q52_UNIT - pw) + (Q52_UNIT >> 1)) >> 52);
        end
    endtask

    task automatic clear_model();
        gain_setting   = RST_GAIN;
        gate_on        = RST_GATE_ENABLE;
        open_thresh    = RST_OPEN_LEVEL;
        close_thresh   = RST_CLOSE_LEVEL;
        hold_setting   = RST_HOLD_FRAMES;
        tx_on          = RST_TX_ENABLE;
        peak_so_far    = '0;
        energy_so_far  = '0;
        words_in_frame = '0;
        gate_is_open   = 1'b0;
        hold_left      = '0;
    endtask

    // gain, round half away from zero, soft knee, clamp; frame gate on the last word
    function automatic voice_word_t gain_limit_gate(logic [15:0] raw, logic last);
        voice_word_t w;
        logic [31:0] amag;
        logic [31:0] m;
        logic [31:0] excess;
        logic [31:0] mag;
        logic [63:0] n;
        logic        loud_enough;
        logic        quiet_enough;
        amag = raw[15] ? (32'h10000 - 32'(raw)) : 32'(raw);
        m    = (amag * 32'(gain_setting) + 32'd2048) >> 12;
        if (m <= KNEE)
            mag = m;
        else
        begin
            excess = m - KNEE;
            // excess past the end of the curve reads its last entry
            if (excess >= KNEE_DEPTH)
                excess = KNEE_DEPTH - 1;
            mag = KNEE + 32'(knee_curve[excess]);
        end
        if (!raw[15] && mag > POS_MAX)
            mag = POS_MAX;
        if (mag > NEG_MAX)
            mag = NEG_MAX;

        w.sample = raw[15] ? 16'(32'd0 - mag) : mag[15:0];
        w.done   = 1'b0;
        w.peak   = '0;
        w.gate   = 1'b0;
        w.tx     = 1'b0;
        w.speak  = 1'b0;

        if (mag > 32'(peak_so_far))
            peak_so_far = mag[15:0];
        // a frame past the count limit still moves the peak, but not energy or count
        if (words_in_frame < COUNT_MAX)
        begin
            energy_so_far  = energy_so_far + 64'(mag) * 64'(mag);
            words_in_frame = words_in_frame + 1'b1;
        end

        if (last)
        begin
            n            = 64'(words_in_frame);
            loud_enough  = energy_so_far >= 64'(open_thresh) * 64'(open_thresh) * n;
            quiet_enough = energy_so_far < 64'(close_thresh) * 64'(close_thresh) * n;
            if (hold_left != 0)
                hold_left = hold_left - 1'b1;
            if (gate_on)
            begin
                if (loud_enough)
                begin
                    gate_is_open = 1'b1;
                    hold_left    = hold_setting;
                end
                else if (gate_is_open && quiet_enough && hold_left == 0)
                    gate_is_open = 1'b0;
            end
            else
                gate_is_open = 1'b0;
            w.done  = 1'b1;
            w.peak  = peak_so_far;
            w.gate  = gate_is_open;
            w.tx    = tx_on && (gate_is_open || !gate_on);
            w.speak = w.tx && (peak_so_far > SPEAK_PEAK);
            peak_so_far    = '0;
            energy_so_far  = '0;
            words_in_frame = '0;
        end
        return w;
    endfunction

    // offer one capture word, predict its result on acceptance, then maybe idle
    task automatic send_word(logic [15:0] raw, logic last);
        int gap;
        @(negedge clk);
        capture_ch.valid      <= 1'b1;
        capture_ch.in_sample  <= raw;
        capture_ch.frame_last <= last;
        do
            @(posedge clk);
        while (capture_ch.ready !== 1'b1);
        expected_words.insert(expected_words.size(), gain_limit_gate(raw, last));
        gap = source_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            capture_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic play_frame(int len, level_t level);
        for (int i = 0; i < len; i++)
            send_word(pick_word(level), i == len - 1);
    endtask

    // sender stops and waits until every owed result word has come out
    task automatic wait_until_idle();
        @(negedge clk);
        capture_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            REG_GAIN:        gain_setting = value[GAIN_W-1:0];
            REG_GATE_ENABLE: gate_on      = value[0];
            REG_OPEN_LEVEL:  open_thresh  = value[OPEN_W-1:0];
            REG_CLOSE_LEVEL: close_thresh = value[CLOSE_W-1:0];
            REG_HOLD_FRAMES: hold_setting = value[HOLD_W-1:0];
            REG_TX_ENABLE:   tx_on        = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_settings(logic [GAIN_W-1:0] gain, logic gate, logic [OPEN_W-1:0] open_lvl,
                                 logic [CLOSE_W-1:0] close_lvl, logic [HOLD_W-1:0] hold,
                                 logic tx);
        write_reg(REG_GAIN, CFG_DATA_W'(gain));
        write_reg(REG_GATE_ENABLE, CFG_DATA_W'(gate));
        write_reg(REG_OPEN_LEVEL, CFG_DATA_W'(open_lvl));
        write_reg(REG_CLOSE_LEVEL, CFG_DATA_W'(close_lvl));
        write_reg(REG_HOLD_FRAMES, CFG_DATA_W'(hold));
        write_reg(REG_TX_ENABLE, CFG_DATA_W'(tx));
    endtask

    // random settings, favoring the nominal ranges and their ends
    task automatic load_random_settings();
        logic [GAIN_W-1:0]  gain;
        logic [OPEN_W-1:0]  open_lvl;
        logic [CLOSE_W-1:0] close_lvl;
        logic [HOLD_W-1:0]  hold;
        case ($urandom_range(0, 5))
            0:       gain = 15'd1382;
            1:       gain = 15'd27648;
            2:       gain = 15'd4096;
            3:       gain = 15'($urandom);
            default: gain = 15'($urandom_range(1382, 27648));
        endcase
        if ($urandom_range(0, 7) == 0)
            open_lvl = 14'($urandom);
        else
            open_lvl = 14'($urandom_range(164, 8192));
        case ($urandom_range(0, 5))
            0:       close_lvl = 13'($urandom);
            1:       close_lvl = 13'($urandom_range(106, 5325));
            default: close_lvl = 13'((32'(open_lvl) * 13) / 20);
        endcase
        case ($urandom_range(0, 5))
            0:       hold = 8'd0;
            1:       hold = 8'd255;
            2:       hold = 8'($urandom);
            default: hold = 8'($urandom_range(1, 4));
        endcase
        load_settings(gain, $urandom_range(0, 4) != 0, open_lvl, close_lvl, hold,
                      $urandom_range(0, 5) != 0);
    endtask

    // hand-picked words: field extremes, knee edges, curve end, gate open and close
    task automatic test_directed();
        // reset settings: gate bypassed, transmit on
        send_word(16'd0, 1'b0);
        send_word(16'd1, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'd22221, 1'b0);
        send_word(16'(-22222), 1'b1);

        // top gain runs past the end of the curve; hold of zero closes at once
        wait_until_idle();
        load_settings(15'd27648, 1'b1, 14'd164, 13'd106, 8'd0, 1'b1);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'd100, 1'b1);
        send_word(16'd0, 1'b1);

        // bottom gain, top levels and hold, transmit off
        wait_until_idle();
        load_settings(15'd1382, 1'b1, 14'd8192, 13'd5325, 8'd255, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b1);

        // close level above open level, unity gain across the knee
        wait_until_idle();
        load_settings(15'd4096, 1'b1, 14'd200, 13'd1000, 8'd1, 1'b1);
        send_word(16'd500, 1'b1);
        send_word(16'd500, 1'b1);
        send_word(16'd0, 1'b1);
        send_word(16'd30000, 1'b0);
        send_word(16'd30001, 1'b0);
        send_word(16'(-30001), 1'b1);
    endtask

    // phases of random settings, each followed by frames of random length and level
    task automatic test_random_traffic();
        int sent;
        int len;
        int phase;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            wait_until_idle();
            if (phase == 0)
                load_settings(15'd1382, 1'b1, 14'd164, 13'd106, 8'd1, 1'b1);
            else if (phase == 1)
                load_settings(15'd27648, 1'b1, 14'd8192, 13'd5325, 8'd255, 1'b1);
            else
                load_random_settings();
            // some phases run with no idling on one side or both
            source_idles = $urandom_range(0, 3) != 0;
            sink_idles   = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(3, 8))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: any word, frame ends dropped at random
                    len = $urandom_range(1, 20);
                    repeat (len) send_word(16'($urandom), $urandom_range(0, 4) == 0);
                end
                else
                begin
                    len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16)
                                                     : $urandom_range(17, 120);
                    play_frame(len, level_t'($urandom_range(0, 4)));
                end
                sent += len;
                if ($urandom_range(0, 7) == 0)
                    wait_until_idle();
            end
            phase++;
        end
    endtask

    // result side held off for a long stretch while words keep coming back to back
    task automatic test_backpressure();
        wait_until_idle();
        load_settings(15'd5530, 1'b1, 14'd655, 13'd426, 8'd2, 1'b1);
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        hold_off_asked++;
        repeat (4) play_frame(12, LEVEL_MIXED);
        wait_until_idle();
    endtask

    // result ready: random stalls, plus a long hold-off when a test asks for one
    always @(negedge clk)
    begin
        if (hold_off_given != hold_off_asked)
        begin
            sink_stall     = HOLD_OFF_CYCLES;
            hold_off_given = hold_off_asked;
        end
        if (sink_stall > 0)
        begin
            result_ch.ready <= 1'b0;
            sink_stall--;
        end
        else if (sink_idles && $urandom_range(0, 99) < 20)
        begin
            result_ch.ready <= 1'b0;
            sink_stall = pick_gap();
        end
        else
            result_ch.ready <= 1'b1;
    end

    task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            fails++;
        end
    endtask

    // each accepted result word against the oldest owed word
    always @(posedge clk)
    begin : check_results
        voice_word_t want;
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t ns: stray result word, expected none, got sample %0d",
                         $time, result_ch.out_sample);
                fails++;
            end
            else
            begin
                want = expected_words.pop_front();
                compare_field("out_sample", want.sample, result_ch.out_sample);
                compare_field("frame_done", want.done, result_ch.frame_done);
                compare_field("frame_peak", want.peak, result_ch.frame_peak);
                compare_field("gate_open", want.gate, result_ch.gate_open);
                compare_field("transmit", want.tx, result_ch.transmit);
                compare_field("speaking", want.speak, result_ch.speaking);
            end
        end
    end

    // watchdog: too long with no word moving on any channel
    always @(posedge clk)
    begin
        if ((capture_ch.valid === 1'b1 && capture_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("capture_gain_limiter_voice_gate_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        capture_ch.valid      = 1'b0;
        capture_ch.in_sample  = '0;
        capture_ch.frame_last = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_GAIN;
        cfg_ch.data           = '0;
        build_knee_curve();
        clear_model();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // the unit fills its curve memory first; the first word waits on ready
        test_directed();
        test_random_traffic();
        test_backpressure();

        wait_until_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("capture_gain_limiter_voice_gate_unit regression: pass");
        else
            $display("capture_gain_limiter_voice_gate_unit regression: fail");
        $finish;
    end

endmodule
